### rtl/tcw_pkg.sv
// Shared types, constants and helpers of the text console writer.
package tcw_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ATTR_W    = 8;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned INDEX_W   = 11;
  localparam int unsigned ROW_OUT_W = 5;
  localparam int unsigned COL_OUT_W = 7;

  localparam logic              OP_PUT       = 1'b0;
  localparam logic              OP_READ      = 1'b1;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h07;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_DONE
  } tcw_state_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  function automatic logic [CELL_W-1:0] form_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] attr);
    return {attr, ch};
  endfunction

endpackage

### rtl/tcw_if.sv
// Request and response channel interfaces of the text console writer.
interface tcw_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::INDEX_W-1:0]  cell_index;

  modport source (output valid, output opcode, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input opcode, input char_code, input cell_index,
                output ready);
endinterface

interface tcw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CELL_W-1:0]    cell_value;
  logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row;
  logic [tcw_pkg::COL_OUT_W-1:0] cursor_column;
  logic                          scrolled;

  modport source (output valid, output cell_value, output cursor_row,
                  output cursor_column, output scrolled, input ready);
  modport sink (input valid, input cell_value, input cursor_row,
                input cursor_column, input scrolled, output ready);
endinterface

### rtl/tcw_screen_mem.sv
// Screen cell memory: one write port, one registered read port.
module tcw_screen_mem #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic                     clk_i,
  input  tcw_pkg::mem_ctl_t        ctl_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tcw_ctrl.sv
// Sequencer: cursor, color register, clear and scroll sweeps, response register.
module tcw_ctrl #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  parameter int unsigned AW      = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata_i,
  tcw_req_if.sink                     req_i,
  tcw_rsp_if.source                   rsp_o,
  output tcw_pkg::mem_ctl_t           mem_ctl_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]  mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]  mem_rdata_i
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned NW    = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);

  localparam logic [NW-1:0] CELLS_N    = NW'(CELLS);
  localparam logic [NW-1:0] CLEAR_LAST = NW'(CELLS - 1);
  localparam logic [NW-1:0] SHIFT_N    = NW'(CELLS - COLUMNS);
  localparam logic [NW-1:0] COLS_N     = NW'(COLUMNS);
  localparam logic [RW:0]   ROWS_R     = (RW + 1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW:0]   COLS_C     = (CW + 1)'(COLUMNS);
  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);

  tcw_state_e        state_q, state_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [ATTR_W-1:0] color_q;
  logic              rd_q, rd_d;
  logic              rng_q, rng_d;
  logic              scr_q, scr_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              rsp_load;

  logic [CELL_W-1:0]    val_q;
  logic [ROW_OUT_W-1:0] row_out_q;
  logic [COL_OUT_W-1:0] col_out_q;
  logic                 scr_out_q;

  logic              accept;
  logic              is_nl;
  logic [CW:0]       col_inc;
  logic [RW:0]       row_inc;
  logic [RW:0]       row_wrap;
  logic              wrap;
  logic              ovf;
  logic [AW-1:0]     put_addr;
  logic              in_rng;
  logic [NW-1:0]     cnt_prev;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_load    = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);

  assign is_nl    = (req_i.char_code == NEWLINE_CODE);
  assign col_inc  = {1'b0, col_q} + (CW + 1)'(1);
  assign row_inc  = {1'b0, row_q} + (RW + 1)'(1);
  assign wrap     = is_nl || (col_inc >= COLS_C);
  assign row_wrap = wrap ? row_inc : {1'b0, row_q};
  assign ovf      = (row_wrap >= ROWS_R);
  assign put_addr = AW'(row_q) * COLS_A + AW'(col_q);
  assign in_rng   = (32'(req_i.cell_index) < 32'(CELLS));
  assign cnt_prev = cnt_q - NW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CLEAR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.opcode == OP_PUT && ovf) state_d = ST_SCROLL;
          else state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        if (cnt_q == CELLS_N) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_load) state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    rd_d        = rd_q;
    rng_d       = rng_q;
    scr_d       = scr_q;
    mem_ctl_o   = '0;
    mem_waddr_o = AW'(cnt_q);
    mem_wdata_o = form_cell(BLANK_CHAR, RESET_COLOR);
    mem_raddr_o = AW'(req_i.cell_index);
    unique case (state_q)
      ST_CLEAR: begin
        mem_ctl_o.we = 1'b1;
        cnt_d        = (cnt_q == CLEAR_LAST) ? '0 : cnt_q + NW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.opcode == OP_READ) begin
            mem_ctl_o.re = 1'b1;
            rd_d         = 1'b1;
            rng_d        = in_rng;
            scr_d        = 1'b0;
          end else begin
            mem_ctl_o.we = !is_nl;
            mem_waddr_o  = put_addr;
            mem_wdata_o  = form_cell(req_i.char_code, color_q);
            rd_d         = 1'b0;
            rng_d        = 1'b0;
            scr_d        = ovf;
            col_d        = wrap ? '0 : col_inc[CW-1:0];
            row_d        = ovf ? LAST_ROW : row_wrap[RW-1:0];
            cnt_d        = '0;
          end
        end
      end
      ST_SCROLL: begin
        mem_ctl_o.re = (cnt_q < SHIFT_N);
        mem_raddr_o  = AW'(cnt_q + COLS_N);
        mem_ctl_o.we = (cnt_q != '0);
        mem_waddr_o  = AW'(cnt_prev);
        mem_wdata_o  = (cnt_q <= SHIFT_N) ? mem_rdata_i : form_cell(BLANK_CHAR, color_q);
        cnt_d        = (cnt_q == CELLS_N) ? '0 : cnt_q + NW'(1);
      end
      ST_DONE: begin
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) rsp_valid_d = 1'b0;
    if (rsp_load) rsp_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      color_q     <= RESET_COLOR;
      rd_q        <= 1'b0;
      rng_q       <= 1'b0;
      scr_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      rd_q        <= rd_d;
      rng_q       <= rng_d;
      scr_q       <= scr_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) color_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      val_q     <= (rd_q && rng_q) ? mem_rdata_i : '0;
      row_out_q <= ROW_OUT_W'(row_q);
      col_out_q <= COL_OUT_W'(col_q);
      scr_out_q <= scr_q;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.cell_value    = val_q;
  assign rsp_o.cursor_row    = row_out_q;
  assign rsp_o.cursor_column = col_out_q;
  assign rsp_o.scrolled      = scr_out_q;

endmodule

### rtl/text_console_writer_unit.sv
// Top level of the text console writer: sequencer and screen memory.
// A put or a read is accepted when ready is high. Its response is loaded from the done state,
// and the block is ready again from the same edge that loads the response; while
// an earlier response still waits on the output, the new response is held back and ready
// stays low until the output frees up. A put that moves the cursor past
// the bottom row also scrolls: the sequencer copies the screen up one row through the
// single write / single read port of the screen memory and fills the last row with blanks.
// After reset a clearing pass writes the blank cell 0x0720 to all ROWS*COLUMNS cells, one a
// cycle, before the first item is accepted; color writes are taken during that pass.
// Accepting an item while an earlier response waits on the output is allowed.
module text_console_writer_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata_i,
  tcw_req_if.sink                     req_i,
  tcw_rsp_if.source                   rsp_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### rtl/tcw_checker.sv
// Port-level assertions of the text console writer and their bind.
module tcw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [tcw_pkg::CELL_W-1:0]    cell_value_i,
  input logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row_i,
  input logic [tcw_pkg::COL_OUT_W-1:0] cursor_column_i,
  input logic                          scrolled_i
);
  import tcw_pkg::*;

  localparam logic [ROW_OUT_W-1:0] LAST_ROW_O = ROW_OUT_W'(ROWS - 1);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(cell_value_i)
      && $stable(cursor_row_i) && $stable(cursor_column_i) && $stable(scrolled_i))
    else $error("response beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken in the cycle after a beat");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> 32'(cursor_column_i) < 32'(COLUMNS))
    else $error("cursor column out of range");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && scrolled_i |-> cursor_row_i == LAST_ROW_O && cell_value_i == '0)
    else $error("scroll without cursor on bottom row");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !rsp_valid_i && !req_ready_i)
    else $error("handshake active during reset");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .cell_value_i    (rsp_o.cell_value),
  .cursor_row_i    (rsp_o.cursor_row),
  .cursor_column_i (rsp_o.cursor_column),
  .scrolled_i      (rsp_o.scrolled)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for text_console_writer_unit: screen puts and reads checked beat by beat.
module tb_top;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS        = 80;
  localparam int unsigned ROWS           = 25;
  localparam int unsigned CELLS          = COLUMNS * ROWS;
  localparam int unsigned ITEM_TARGET    = 420;
  localparam int unsigned WATCHDOG_LIMIT = 12000;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_value;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_column;
    logic                 scrolled;
  } console_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcw_req_if req_bus ();
  tcw_rsp_if rsp_bus ();

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  logic [CELL_W-1:0]    screen_model [CELLS];
  logic [ROW_OUT_W-1:0] row_model;
  logic [COL_OUT_W-1:0] col_model;
  logic [ATTR_W-1:0]    color_model;

  console_result_t pending_results [$];
  console_result_t oldest_result;
  int unsigned     mismatch_count = 0;
  int unsigned     items_sent     = 0;
  int unsigned     quiet_cycles   = 0;
  bit              no_idle        = 1'b0;

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic console_result_t apply_console_item(input logic op,
                                                         input logic [CHAR_W-1:0] ch,
                                                         input logic [INDEX_W-1:0] idx);
    console_result_t res;
    logic [CELL_W-1:0] blank;
    int unsigned i;
    res = '0;
    if (op == OP_READ) begin
      if (idx < CELLS) res.cell_value = screen_model[idx];
    end else begin
      if (ch == NEWLINE_CODE) begin
        col_model = '0;
        row_model = row_model + ROW_OUT_W'(1);
      end else begin
        screen_model[row_model * COLUMNS + col_model] = {color_model, ch};
        col_model = col_model + COL_OUT_W'(1);
        if (col_model >= COLUMNS) begin
          col_model = '0;
          row_model = row_model + ROW_OUT_W'(1);
        end
      end
      if (row_model >= ROWS) begin
        blank = {color_model, BLANK_CHAR};
        for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = blank;
        row_model   = ROW_OUT_W'(ROWS - 1);
        res.scrolled = 1'b1;
      end
    end
    res.cursor_row    = row_model;
    res.cursor_column = col_model;
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_bus.valid      <= 1'b1;
    req_bus.opcode     <= op;
    req_bus.char_code  <= ch;
    req_bus.cell_index <= idx;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    pending_results.push_back(apply_console_item(op, ch, idx));
    items_sent++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(OP_PUT, ch, INDEX_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [INDEX_W-1:0] idx);
    send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    @(posedge clk);
    while (req_bus.ready !== 1'b1) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_color(input logic [ATTR_W-1:0] color);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(negedge clk);
    cfg_we <= 1'b0;
    color_model = color;
  endtask

  task automatic test_directed_cases();
    read_cell(0);
    read_cell(INDEX_W'(CELLS - 1));
    read_cell(INDEX_W'(CELLS));
    read_cell(11'h7FF);
    put_char(8'h00);
    put_char(8'hFF);
    send_item(OP_PUT, 8'h41, 11'h7FF);
    put_char(8'h09);
    put_char(NEWLINE_CODE);
    put_char(8'h0B);
    send_item(OP_READ, NEWLINE_CODE, 11'd2);
    read_cell(0);
    read_cell(1);
    read_cell(3);
    read_cell(INDEX_W'(COLUMNS));
    write_color(8'hF0);
    put_char(8'h7E);
    read_cell(INDEX_W'(COLUMNS + 1));
    read_cell(11'h400);
  endtask

  task automatic test_wrap_and_scroll();
    write_color(8'hFF);
    while (row_model != ROWS - 1) put_char(NEWLINE_CODE);
    put_char(NEWLINE_CODE);
    read_cell(INDEX_W'(CELLS - COLUMNS));
    read_cell(INDEX_W'(CELLS - 1));
    read_cell(INDEX_W'(CELLS - COLUMNS - 1));
    write_color(8'h00);
    repeat (COLUMNS) put_char(CHAR_W'($urandom_range(32, 126)));
    read_cell(INDEX_W'(CELLS - COLUMNS));
    read_cell(INDEX_W'(CELLS - 2 * COLUMNS));
    repeat (COLUMNS - 1) put_char(CHAR_W'($urandom_range(0, 255)) | 8'h80);
    read_cell(INDEX_W'(CELLS - 2));
    read_cell(INDEX_W'(CELLS - 1));
    put_char(NEWLINE_CODE);
  endtask

  task automatic test_random_traffic();
    int unsigned phase_end;
    int unsigned choice;
    int unsigned burst;
    int unsigned back;
    int unsigned cursor_cell;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] color;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       color = 8'h00;
        1:       color = 8'hFF;
        2:       color = RESET_COLOR;
        default: color = ATTR_W'($urandom_range(0, 255));
      endcase
      write_color(color);
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + 40;
      while (items_sent < phase_end) begin
        choice = $urandom_range(0, 99);
        if (choice < 55) begin
          burst = $urandom_range(1, 40);
          repeat (burst) begin
            ch = ($urandom_range(0, 3) == 0) ? CHAR_W'($urandom_range(0, 255))
                                             : CHAR_W'($urandom_range(32, 126));
            put_char(ch);
          end
        end else if (choice < 70) begin
          put_char(NEWLINE_CODE);
        end else if (choice < 92) begin
          cursor_cell = row_model * COLUMNS + col_model;
          back        = $urandom_range(1, 3 * COLUMNS);
          read_cell(INDEX_W'(cursor_cell >= back ? cursor_cell - back
                                                 : $urandom_range(0, CELLS - 1)));
        end else begin
          read_cell(INDEX_W'($urandom_range(0, 2047)));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall;
    rsp_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        @(negedge clk);
        rsp_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (rsp_bus.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none pending: cell %h row %0d col %0d scrolled %0b",
                 $time, rsp_bus.cell_value, rsp_bus.cursor_row, rsp_bus.cursor_column,
                 rsp_bus.scrolled);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_bus.cell_value !== oldest_result.cell_value) begin
          $display("%0t: cell_value expected %h actual %h", $time,
                   oldest_result.cell_value, rsp_bus.cell_value);
          mismatch_count++;
        end
        if (rsp_bus.cursor_row !== oldest_result.cursor_row) begin
          $display("%0t: cursor_row expected %0d actual %0d", $time,
                   oldest_result.cursor_row, rsp_bus.cursor_row);
          mismatch_count++;
        end
        if (rsp_bus.cursor_column !== oldest_result.cursor_column) begin
          $display("%0t: cursor_column expected %0d actual %0d", $time,
                   oldest_result.cursor_column, rsp_bus.cursor_column);
          mismatch_count++;
        end
        if (rsp_bus.scrolled !== oldest_result.scrolled) begin
          $display("%0t: scrolled expected %0b actual %0b", $time,
                   oldest_result.scrolled, rsp_bus.scrolled);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("text_console_writer_unit verification failed");
      $finish;
    end
  end

  initial begin
    req_bus.valid      = 1'b0;
    req_bus.opcode     = OP_PUT;
    req_bus.char_code  = '0;
    req_bus.cell_index = '0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    rst_n              = 1'b0;
    row_model          = '0;
    col_model          = '0;
    color_model        = RESET_COLOR;
    for (int i = 0; i < CELLS; i++) screen_model[i] = {RESET_COLOR, BLANK_CHAR};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_wrap_and_scroll();
    test_random_traffic();

    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_console_writer_unit verification clean");
    end else begin
      $display("text_console_writer_unit verification failed");
    end
    $finish;
  end

endmodule

### text_console_writer_unit.f
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_screen_mem.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_unit.sv
rtl/tcw_checker.sv
test/tb_top.sv
